// ===== hdl/imd_pkg.sv =====
// Shared types for the integer matrix determinant: micro-op and jump codes,
// the control word, sequencer flags and the microprogram ROM.
// No dependencies.
package imd_pkg;

  localparam int PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_DINIT = 4'd1,
    OP_DRD   = 4'd2,
    OP_DWR   = 4'd3,
    OP_MINIT = 4'd4,
    OP_MRD   = 4'd5,
    OP_MMUL  = 4'd6,
    OP_MACC  = 4'd7,
    OP_MWR   = 4'd8,
    OP_SWAP  = 4'd9,
    OP_FRD   = 4'd10,
    OP_FOUT  = 4'd11,
    OP_NOP   = 4'd12
  } op_e;

  typedef enum logic [3:0] {
    COND_NEVER         = 4'd0,
    COND_ALWAYS        = 4'd1,
    COND_NOT_LOADED    = 4'd2,
    COND_ORDER_ONE     = 4'd3,
    COND_I_NOT_ONE     = 4'd4,
    COND_K_NOT_LAST    = 4'd5,
    COND_IJ_NOT_LAST   = 4'd6,
    COND_ITER_NOT_DONE = 4'd7,
    COND_OUT_FULL      = 4'd8
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic loaded;
    logic order_one;
    logic i_is_one;
    logic k_last;
    logic ij_last;
    logic iter_done;
    logic out_full;
  } flags_t;

  // Microprogram addresses
  localparam pc_t PcLoad  = 4'd0;
  localparam pc_t PcDinit = 4'd1;
  localparam pc_t PcDrd   = 4'd2;
  localparam pc_t PcDwr   = 4'd3;
  localparam pc_t PcMinit = 4'd4;
  localparam pc_t PcMrd   = 4'd5;
  localparam pc_t PcMmul  = 4'd6;
  localparam pc_t PcMacc  = 4'd7;
  localparam pc_t PcMwr   = 4'd8;
  localparam pc_t PcSwap  = 4'd9;
  localparam pc_t PcFrd   = 4'd10;
  localparam pc_t PcFout  = 4'd11;
  localparam pc_t PcBack  = 4'd12;

  // Division-free determinant: repeat X <- mu(X) * A, order-1 times.
  // A taken jump goes to target, otherwise the step counter advances.
  function automatic ctl_t ucode_rom(input pc_t pc);
    ctl_t w;
    case (pc)
      PcLoad:  w = '{op: OP_LOAD,  cond: COND_NOT_LOADED,    target: PcLoad};
      PcDinit: w = '{op: OP_DINIT, cond: COND_ORDER_ONE,     target: PcFrd};
      PcDrd:   w = '{op: OP_DRD,   cond: COND_NEVER,         target: PcLoad};
      PcDwr:   w = '{op: OP_DWR,   cond: COND_I_NOT_ONE,     target: PcDrd};
      PcMinit: w = '{op: OP_MINIT, cond: COND_NEVER,         target: PcLoad};
      PcMrd:   w = '{op: OP_MRD,   cond: COND_NEVER,         target: PcLoad};
      PcMmul:  w = '{op: OP_MMUL,  cond: COND_NEVER,         target: PcLoad};
      PcMacc:  w = '{op: OP_MACC,  cond: COND_K_NOT_LAST,    target: PcMrd};
      PcMwr:   w = '{op: OP_MWR,   cond: COND_IJ_NOT_LAST,   target: PcMrd};
      PcSwap:  w = '{op: OP_SWAP,  cond: COND_ITER_NOT_DONE, target: PcDinit};
      PcFrd:   w = '{op: OP_FRD,   cond: COND_NEVER,         target: PcLoad};
      PcFout:  w = '{op: OP_FOUT,  cond: COND_OUT_FULL,      target: PcFout};
      PcBack:  w = '{op: OP_NOP,   cond: COND_ALWAYS,        target: PcLoad};
      default: w = '{op: OP_NOP,   cond: COND_ALWAYS,        target: PcLoad};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/imd_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on imd_pkg.
module imd_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  imd_pkg::flags_t flags_i,
  output imd_pkg::ctl_t   ctl_o
);

  imd_pkg::pc_t pc_q, pc_d;
  logic         take;

  assign ctl_o = imd_pkg::ucode_rom(pc_q);

  always_comb begin
    case (ctl_o.cond)
      imd_pkg::COND_NEVER:         take = 1'b0;
      imd_pkg::COND_ALWAYS:        take = 1'b1;
      imd_pkg::COND_NOT_LOADED:    take = !flags_i.loaded;
      imd_pkg::COND_ORDER_ONE:     take = flags_i.order_one;
      imd_pkg::COND_I_NOT_ONE:     take = !flags_i.i_is_one;
      imd_pkg::COND_K_NOT_LAST:    take = !flags_i.k_last;
      imd_pkg::COND_IJ_NOT_LAST:   take = !flags_i.ij_last;
      imd_pkg::COND_ITER_NOT_DONE: take = !flags_i.iter_done;
      imd_pkg::COND_OUT_FULL:      take = flags_i.out_full;
      default:                     take = 1'b1;
    endcase
    pc_d = take ? ctl_o.target : pc_q + imd_pkg::pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= imd_pkg::PcLoad;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/integer_matrix_determinant.sv =====
// Integer matrix determinant, microcoded. Elements load at one per cycle while in_ready_o
// is high. After the last element, order n >= 2 computes the result by repeated 32x32
// multiply-accumulates, each a read, multiply and accumulate step through the
// single-read-port element memories; order 1 goes straight to the output step. The
// sequencer then returns to loading, and the next load may start while the result waits.
// Reset (rst_ni low, async) clears control, sets the order to 4; stores are not cleared.
// Depends on imd_pkg and imd_seq.
module integer_matrix_determinant #(
  parameter int MAX_ORDER = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  matrix_size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] element_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] determinant_value_o
);

  localparam int IW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int AW     = 2 * IW;
  localparam int ADEPTH = 1 << AW;
  localparam int DDEPTH = 1 << IW;

  imd_pkg::ctl_t   ctl;
  imd_pkg::flags_t flags;

  logic [2:0]    size_q;
  logic [IW-1:0] n_m1;
  logic [IW-1:0] row_q, col_q;
  logic          loaded_q;
  logic [IW-1:0] i_q, j_q, k_q, iter_q;
  logic          bank_q;
  logic          diag_q;
  logic [31:0]   d_q, acc_q, prod_q, res_q;
  logic          out_valid_q;
  logic [31:0]   ar_q, xr_q;
  logic [31:0]   amem [ADEPTH];
  logic [31:0]   xmem [2*ADEPTH];
  logic [31:0]   dreg_q [DDEPTH];

  logic          in_acc;
  logic          xwe;
  logic [AW:0]   xwaddr, xraddr;
  logic [31:0]   xwdata;
  logic [31:0]   mu, d_nx;
  logic [31:0]   mult;
  logic [IW-1:0] iter_nx;

  imd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctl_o  (ctl)
  );

  // Clamp the configured size into 1..MAX_ORDER, kept as order minus one
  always_comb begin
    if (size_q == 3'd0) begin
      n_m1 = '0;
    end else if (int'(size_q) > MAX_ORDER) begin
      n_m1 = IW'(MAX_ORDER - 1);
    end else begin
      n_m1 = IW'(size_q - 3'd1);
    end
  end

  assign in_ready_o          = (ctl.op == imd_pkg::OP_LOAD) && !loaded_q;
  assign in_acc              = in_valid_i && in_ready_o;
  assign out_valid_o         = out_valid_q;
  assign determinant_value_o = res_q;

  assign iter_nx = iter_q + IW'(1);

  always_comb begin
    flags.loaded    = loaded_q;
    flags.order_one = (n_m1 == '0);
    flags.i_is_one  = (i_q == IW'(1));
    flags.k_last    = (k_q == n_m1);
    flags.ij_last   = (i_q == n_m1) && (j_q == n_m1);
    flags.iter_done = (iter_nx == n_m1);
    flags.out_full  = out_valid_q;
  end

  // Working matrix lives in two banks; the load fills bank 0 with A
  always_comb begin
    xwe    = in_acc || (ctl.op == imd_pkg::OP_MWR);
    xwaddr = in_acc ? {1'b0, row_q, col_q} : {~bank_q, i_q, j_q};
    xwdata = in_acc ? element_value_i : acc_q;
    case (ctl.op)
      imd_pkg::OP_DRD:                  xraddr = {bank_q, i_q, i_q};
      // hold the top-left entry while the result waits for the output
      imd_pkg::OP_FRD, imd_pkg::OP_FOUT: xraddr = {bank_q, {AW{1'b0}}};
      default:                          xraddr = {bank_q, i_q, k_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      amem[{row_q, col_q}] <= element_value_i;
    end
    if (xwe) begin
      xmem[xwaddr] <= xwdata;
    end
    ar_q <= amem[{k_q, j_q}];
    xr_q <= xmem[xraddr];
  end

  assign mu   = diag_q ? dreg_q[i_q] : xr_q;
  assign mult = mu * ar_q;
  assign d_nx = d_q - xr_q;

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    case (ctl.op)
      imd_pkg::OP_DINIT: begin
        d_q          <= '0;
        dreg_q[n_m1] <= '0;
      end
      imd_pkg::OP_DWR: begin
        d_q                     <= d_nx;
        dreg_q[i_q - IW'(1)]    <= d_nx;
      end
      imd_pkg::OP_MINIT: acc_q  <= '0;
      imd_pkg::OP_MRD:   diag_q <= (k_q == i_q);
      imd_pkg::OP_MMUL:  prod_q <= mult;
      imd_pkg::OP_MACC:  acc_q  <= acc_q + prod_q;
      imd_pkg::OP_MWR:   acc_q  <= '0;
      imd_pkg::OP_FOUT: begin
        if (!out_valid_q) begin
          res_q <= n_m1[0] ? (32'd0 - xr_q) : xr_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= 3'd4;
      row_q       <= '0;
      col_q       <= '0;
      loaded_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      iter_q      <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        size_q <= matrix_size_i;
        row_q  <= '0;
        col_q  <= '0;
      end else if (in_acc) begin
        if (col_q == n_m1) begin
          col_q <= '0;
          if (row_q == n_m1) begin
            // last element: hand the matrix to the sequencer
            row_q    <= '0;
            loaded_q <= 1'b1;
            bank_q   <= 1'b0;
            iter_q   <= '0;
          end else begin
            row_q <= row_q + IW'(1);
          end
        end else begin
          col_q <= col_q + IW'(1);
        end
      end
      case (ctl.op)
        imd_pkg::OP_DINIT: begin
          loaded_q <= 1'b0;
          i_q      <= n_m1;
        end
        imd_pkg::OP_DWR: i_q <= i_q - IW'(1);
        imd_pkg::OP_MINIT: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
        end
        imd_pkg::OP_MACC: k_q <= k_q + IW'(1);
        imd_pkg::OP_MWR: begin
          if (j_q == n_m1) begin
            j_q <= '0;
            i_q <= i_q + IW'(1);
            k_q <= i_q + IW'(1);
          end else begin
            j_q <= j_q + IW'(1);
            k_q <= i_q;
          end
        end
        imd_pkg::OP_SWAP: begin
          bank_q <= ~bank_q;
          iter_q <= iter_nx;
        end
        imd_pkg::OP_FOUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_result_from_fout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.op == imd_pkg::OP_FOUT))
    else $error("result raised outside the output step");

  a_k_not_below_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == imd_pkg::OP_MACC) |-> (k_q >= i_q))
    else $error("inner index below row index");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == imd_pkg::OP_SWAP) |-> (iter_q < n_m1))
    else $error("iteration count overran the order");

  a_no_load_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op != imd_pkg::OP_LOAD) |-> !in_ready_o)
    else $error("input ready while computing");

endmodule

// ===== sim/integer_matrix_determinant_tb.sv =====
// Self-checking testbench for integer_matrix_determinant: streams matrices through
// the valid/ready element port and checks each determinant against a local predictor.
// Depends on the RTL in hdl/ (imd_pkg, imd_seq and the top level) only.
`timescale 1ns / 100ps

module integer_matrix_determinant_tb;

  localparam int MAX_ORDER     = 4;
  localparam int ITEM_TARGET   = 1200;
  localparam int SETTLE_CYCLES = 500;   // settle time for an order-4 expansion after its last element
  localparam int PARK_CYCLES   = 3000;

  typedef logic [8:0][31:0]  mat3_t;
  typedef logic [15:0][31:0] mat4_t;

  typedef struct packed {
    logic        wr;
    logic [2:0]  size;
    logic [31:0] elem;
    logic        pin;
    logic [31:0] det;
  } stim_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  matrix_size_i   = 3'd4;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [31:0] element_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [31:0] determinant_value_o;

  // Sideband that travels with the element: a determinant typed into the table.
  logic        pin_on  = 1'b0;
  logic [31:0] pin_det = '0;

  // Predictor state
  logic [2:0]  size_reg = 3'd4;
  int unsigned filled   = 0;
  mat4_t       store_words = '0;
  logic [31:0] det_queue[$];

  logic [31:0] want_det;
  int          mismatch_count = 0;
  int          items_sent     = 0;
  bit          gaps_on        = 1'b1;
  bit          park_req       = 1'b0;

  integer_matrix_determinant #(
    .MAX_ORDER(MAX_ORDER)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .matrix_size_i      (matrix_size_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .element_value_i    (element_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .determinant_value_o(determinant_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int order_of(input logic [2:0] size);
    if (size == 3'd0) return 1;
    if (size > MAX_ORDER) return MAX_ORDER;
    return size;
  endfunction

  function automatic logic [31:0] det3(input mat3_t s);
    return s[0] * (s[4] * s[8] - s[5] * s[7])
         - s[1] * (s[3] * s[8] - s[5] * s[6])
         + s[2] * (s[3] * s[7] - s[4] * s[6]);
  endfunction

  // All products wrap at 32 bits, which matches exact arithmetic reduced mod 2^32.
  function automatic logic [31:0] det_wrapped(input mat4_t m, input int n);
    mat3_t       sub;
    logic [31:0] acc;
    int          k;
    acc = '0;
    case (n)
      1: acc = m[0];
      2: acc = m[0] * m[3] - m[1] * m[2];
      3: acc = det3(m[8:0]);
      default: begin
        for (int col = 0; col < 4; col++) begin
          k = 0;
          for (int r = 1; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              if (c != col) begin
                sub[k] = m[r*4 + c];
                k++;
              end
            end
          end
          if (col % 2 == 0) acc = acc + m[col] * det3(sub);
          else acc = acc - m[col] * det3(sub);
        end
      end
    endcase
    return acc;
  endfunction

  function automatic stim_row_t step_row(input logic wr, input logic [2:0] size,
                                         input logic [31:0] elem, input logic pin,
                                         input logic [31:0] det);
    stim_row_t row;
    row.wr   = wr;
    row.size = size;
    row.elem = elem;
    row.pin  = pin;
    row.det  = det;
    return row;
  endfunction

  function automatic logic [31:0] draw_element();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_element(input logic [31:0] value, input logic pinned,
                               input logic [31:0] pinned_det);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    pin_on          <= pinned;
    pin_det         <= pinned_det;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (det_queue.size() != 0);
    @(posedge clk_i);
  endtask

  // Drain, let a partly loaded matrix or a running expansion settle, then write.
  task automatic write_size(input logic [2:0] size);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    matrix_size_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Predict on every accepted item and every register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        size_reg = matrix_size_i;
        filled   = 0;
      end
      if (in_valid_i && in_ready_o) begin
        if (filled >= order_of(size_reg) ** 2) filled = 0;
        store_words[filled] = element_value_i;
        filled++;
        if (filled == order_of(size_reg) ** 2) begin
          filled = 0;
          det_queue.push_back(pin_on ? pin_det : det_wrapped(store_words, order_of(size_reg)));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (det_queue.size() == 0) begin
        $error("determinant_value: expected none, actual %h", determinant_value_o);
        mismatch_count++;
      end else begin
        want_det = det_queue.pop_front();
        if (determinant_value_o !== want_det) begin
          $error("determinant_value: expected %h, actual %h", want_det, determinant_value_o);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (park_req) begin
        park_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    stim_row_t   directed_rows[$];
    logic [2:0]  size;
    int          n;
    int          nmat;
    int          phase_idx;
    bit          pressure;

    // Reset order is 4: a partial load, then a size write must discard it.
    directed_rows.push_back(step_row(1'b0, 3'd0, 32'h7fff_ffff, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd0, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd0, 32'h0000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd0, 32'hffff_ffff, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd0, 32'h0000_0001, 1'b0, '0));
    // Order 1: the determinant is the element itself.
    directed_rows.push_back(step_row(1'b1, 3'd1, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff));
    directed_rows.push_back(step_row(1'b0, 3'd1, 32'h8000_0000, 1'b1, 32'h8000_0000));
    directed_rows.push_back(step_row(1'b0, 3'd1, 32'h0000_0000, 1'b1, 32'h0000_0000));
    directed_rows.push_back(step_row(1'b0, 3'd1, 32'hffff_ffff, 1'b1, 32'hffff_ffff));
    // Size zero runs as order 1.
    directed_rows.push_back(step_row(1'b1, 3'd0, 32'h0000_0005, 1'b1, 32'h0000_0005));
    // [max min; min max] wraps to 1.
    directed_rows.push_back(step_row(1'b1, 3'd2, 32'h7fff_ffff, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd2, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd2, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd2, 32'h7fff_ffff, 1'b1, 32'h0000_0001));
    directed_rows.push_back(step_row(1'b1, 3'd3, 32'h7fff_ffff, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'hffff_ffff, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'h0000_0001, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'h0000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'h1234_5678, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'h7fff_ffff, 1'b0, '0));
    directed_rows.push_back(step_row(1'b0, 3'd3, 32'hdead_beef, 1'b0, '0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr) write_size(directed_rows[i].size);
      offer_element(directed_rows[i].elem, directed_rows[i].pin, directed_rows[i].det);
    end

    // Random phases: walk every size code first, then one parked order-4 phase, then pick at random.
    phase_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET * 5 / 6) gaps_on = 1'b0;
      pressure = (phase_idx == 8);
      size = pressure ? 3'd4 : (phase_idx < 8 ? 3'(phase_idx) : 3'($urandom_range(0, 7)));
      write_size(size);
      n = order_of(size);
      nmat = pressure ? 3 : $urandom_range(1, 6);
      // Park the result side so the block fills up and stalls its input.
      if (pressure) park_req = 1'b1;
      repeat (nmat * n * n) offer_element(draw_element(), 1'b0, '0);
      // Leave a partial matrix behind for the next size write to discard.
      if (n > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, n * n - 1)) offer_element(draw_element(), 1'b0, '0);
      phase_idx++;
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (det_queue.size() != 0) begin
      $error("determinant_value: %0d expected results never arrived", det_queue.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
